// File: design/shamd_pkg.sv
package shamd_pkg;

   // Depth of the queue between the front end and the hash engine.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = QPTR_W + 1;

   // Round counter and byte fill widths.
   localparam int ROUND_W  = 7;
   localparam int FILL_W   = 6;
   localparam int COUNT_W  = 61;
   localparam int DIGEST_W = 160;

   typedef logic [31:0] word_type;
   typedef word_type [4:0] hash_type;
   typedef word_type [15:0] block_type;

   // One queued request after classification.
   typedef struct packed {
      logic [7:0] msg_byte;
      logic       byte_present;
      logic       end_of_message;
   } entry_type;

   localparam word_type K_00_19 = 32'h5A827999;
   localparam word_type K_20_39 = 32'h6ED9EBA1;
   localparam word_type K_40_59 = 32'h8F1BBCDC;
   localparam word_type K_60_79 = 32'hCA62C1D6;

   // Word 0 of the hash sits in the lowest bits.
   localparam hash_type INIT_HASH = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                     32'hEFCDAB89, 32'h67452301};

   localparam logic [7:0]        PAD_BYTE   = 8'h80;
   localparam logic [FILL_W-1:0] LAST_POS   = 6'd63;
   localparam logic [FILL_W-1:0] LENGTH_POS = 6'd56;
   localparam logic [ROUND_W-1:0] LAST_ROUND = 7'd79;

   // Round constant for a given round number.
   function automatic word_type round_k(input logic [ROUND_W-1:0] r);
      word_type k;
      if (r < 7'd20) begin
         k = K_00_19;
      end else if (r < 7'd40) begin
         k = K_20_39;
      end else if (r < 7'd60) begin
         k = K_40_59;
      end else begin
         k = K_60_79;
      end
      return k;
   endfunction

   // Boolean round function: choose, parity, majority, parity.
   function automatic word_type round_f(input logic [ROUND_W-1:0] r,
                                        input word_type b, input word_type c,
                                        input word_type d);
      word_type f;
      if (r < 7'd20) begin
         f = (b & c) | (~b & d);
      end else if (r < 7'd40) begin
         f = b ^ c ^ d;
      end else if (r < 7'd60) begin
         f = (b & c) | (b & d) | (c & d);
      end else begin
         f = b ^ c ^ d;
      end
      return f;
   endfunction

endpackage

// File: design/sha1_message_digest.sv
// Channel   Direction  Handshake              Payload
// req       in         req_tvalid/req_tready  tdata msg_byte, tuser byte_present, tlast end
// rsp       out        rsp_tvalid/rsp_tready  tdata digest words 0..4, word 0 lowest
//
// Each message byte is shifted into the block by the hash engine; a full 64-byte block then
// runs the rounds (S_ROUND) and the chaining update (S_ADD) on the single shared round unit.
// Finishing a message shifts padding bytes in up to the block end and runs one or two
// more compressions before the digest is registered.
// A four-entry request queue lets requests arrive while the rounds run.
// Reset is synchronous and active high; it restores the initial chaining value.
// A stalled digest holds only the engine; queued requests still enter.
module sha1_message_digest (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] msg_byte
   input  logic         req_tuser,   // [0] byte_present
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [159:0] rsp_tdata    // [31:0] word0, [63:32] word1, ... [159:128] word4
);
   import shamd_pkg::*;

   logic      q_valid;
   logic      q_pop;
   entry_type q_entry;

   // Intake and classification of requests.
   shamd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .q_valid    (q_valid),
      .q_entry    (q_entry),
      .q_pop      (q_pop)
   );

   // Padding, compression and digest output.
   shamd_core u_core (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_entry    (q_entry),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// File: design/shamd_front.sv
module shamd_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,  // [7:0] msg_byte
   input  logic                  req_tuser,  // [0] byte_present
   input  logic                  req_tlast,
   output logic                  q_valid,
   output shamd_pkg::entry_type  q_entry,
   input  logic                  q_pop
);
   import shamd_pkg::*;

   entry_type          mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               push;
   logic               keep;

   // A request with neither a byte nor an end mark changes nothing and is dropped.
   assign keep       = req_tuser | req_tlast;
   assign req_tready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign push       = req_tvalid & req_tready & keep;

   assign q_valid = (count_ff != '0);
   assign q_entry = mem_ff[rd_ptr_ff];

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + QPTR_W'(1);
      end
      if (q_pop) begin
         rd_ptr_in = rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !q_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (!push && q_pop) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= '{msg_byte: req_tdata, byte_present: req_tuser,
                                end_of_message: req_tlast};
      end
   end

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue occupancy exceeds depth");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("queue popped while empty");

   a_full_stalls: assert property (@(posedge clock) disable iff (reset)
      (count_ff == QCNT_W'(QUEUE_DEPTH)) && !q_pop |=> !req_tready)
      else $error("full queue did not stall requests");
`endif

endmodule

// File: design/shamd_core.sv
module shamd_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_valid,
   input  shamd_pkg::entry_type        q_entry,
   output logic                        q_pop,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [shamd_pkg::DIGEST_W-1:0] rsp_tdata
);
   import shamd_pkg::*;

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_PAD_80   = 3'd1;
   localparam logic [2:0] S_PAD_ZERO = 3'd2;
   localparam logic [2:0] S_PAD_LEN  = 3'd3;
   localparam logic [2:0] S_ROUND    = 3'd4;
   localparam logic [2:0] S_ADD      = 3'd5;
   localparam logic [2:0] S_OUT      = 3'd6;

   logic [2:0]          state_ff, state_in;
   logic [2:0]          ret_ff, ret_in;
   logic [ROUND_W-1:0]  round_ff, round_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   hash_type            chain_ff, chain_in;
   hash_type            work_ff, work_in;
   block_type           w_ff, w_in;
   logic                rsp_valid_ff, rsp_valid_in;
   hash_type            rsp_data_ff, rsp_data_in;
   logic [63:0]         bit_length;
   logic [7:0]          length_byte;
   word_type            temp;
   word_type            next_w;

   // Shift one byte into the bottom of the block; the first byte ends up most significant.
   function automatic block_type shift_byte(input block_type w, input logic [7:0] b);
      block_type r;
      for (int j = 0; j < 15; j++) begin
         r[j] = {w[j][23:0], w[j+1][31:24]};
      end
      r[15] = {w[15][23:0], b};
      return r;
   endfunction

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Length field bytes, most significant first.
   assign bit_length  = {count_ff, 3'b000};
   assign length_byte = bit_length[{~fill_ff[2:0], 3'b000} +: 8];

   // One compression round and the message schedule word for sixteen rounds ahead.
   assign temp = {work_ff[0][26:0], work_ff[0][31:27]}
               + round_f(round_ff, work_ff[1], work_ff[2], work_ff[3])
               + work_ff[4] + round_k(round_ff) + w_ff[0];
   assign next_w = {w_ff[13] ^ w_ff[8] ^ w_ff[2] ^ w_ff[0]} << 1
                 | {31'd0, w_ff[13][31] ^ w_ff[8][31] ^ w_ff[2][31] ^ w_ff[0][31]};

   // Sequencer: byte intake, padding, rounds, chaining update, digest output.
   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      round_in     = round_ff;
      fill_in      = fill_ff;
      count_in     = count_ff;
      chain_in     = chain_ff;
      work_in      = work_ff;
      w_in         = w_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      q_pop        = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               if (q_entry.byte_present) begin
                  w_in     = shift_byte(w_ff, q_entry.msg_byte);
                  fill_in  = fill_ff + FILL_W'(1);
                  count_in = count_ff + COUNT_W'(1);
                  if (fill_ff == LAST_POS) begin
                     state_in = S_ROUND;
                     ret_in   = q_entry.end_of_message ? S_PAD_80 : S_IDLE;
                     work_in  = chain_ff;
                  end else if (q_entry.end_of_message) begin
                     state_in = S_PAD_80;
                  end
               end else if (q_entry.end_of_message) begin
                  state_in = S_PAD_80;
               end
            end
         end
         S_PAD_80: begin
            w_in    = shift_byte(w_ff, PAD_BYTE);
            fill_in = fill_ff + FILL_W'(1);
            if (fill_ff == LAST_POS) begin
               state_in = S_ROUND;
               ret_in   = S_PAD_ZERO;
               work_in  = chain_ff;
            end else begin
               state_in = S_PAD_ZERO;
            end
         end
         S_PAD_ZERO: begin
            if (fill_ff == LENGTH_POS) begin
               state_in = S_PAD_LEN;
            end else begin
               w_in    = shift_byte(w_ff, 8'h00);
               fill_in = fill_ff + FILL_W'(1);
               if (fill_ff == LAST_POS) begin
                  state_in = S_ROUND;
                  ret_in   = S_PAD_ZERO;
                  work_in  = chain_ff;
               end
            end
         end
         S_PAD_LEN: begin
            w_in    = shift_byte(w_ff, length_byte);
            fill_in = fill_ff + FILL_W'(1);
            if (fill_ff == LAST_POS) begin
               state_in = S_ROUND;
               ret_in   = S_OUT;
               work_in  = chain_ff;
            end
         end
         S_ROUND: begin
            work_in[0] = temp;
            work_in[1] = work_ff[0];
            work_in[2] = {work_ff[1][1:0], work_ff[1][31:2]};
            work_in[3] = work_ff[2];
            work_in[4] = work_ff[3];
            for (int j = 0; j < 15; j++) begin
               w_in[j] = w_ff[j+1];
            end
            w_in[15] = next_w;
            if (round_ff == LAST_ROUND) begin
               round_in = '0;
               state_in = S_ADD;
            end else begin
               round_in = round_ff + ROUND_W'(1);
            end
         end
         S_ADD: begin
            for (int j = 0; j < 5; j++) begin
               chain_in[j] = chain_ff[j] + work_ff[j];
            end
            state_in = ret_ff;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = chain_ff;
               chain_in     = INIT_HASH;
               count_in     = '0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state and chaining value.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ret_ff       <= S_IDLE;
         round_ff     <= '0;
         fill_ff      <= '0;
         count_ff     <= '0;
         chain_ff     <= INIT_HASH;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         round_ff     <= round_in;
         fill_ff      <= fill_in;
         count_ff     <= count_in;
         chain_ff     <= chain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Block buffer, working variables and output data.
   always_ff @(posedge clock) begin
      work_ff     <= work_in;
      w_ff        <= w_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTH
   a_round_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_ROUND |-> round_ff == '0)
      else $error("round counter running outside the rounds");

   a_block_full: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ADD |-> fill_ff == '0)
      else $error("chaining update with a partly filled block");

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == S_IDLE) && q_valid)
      else $error("queue popped while the engine is busy");

   a_len_pos: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_PAD_LEN |-> fill_ff[5:3] == 3'b111)
      else $error("length field placed outside the last eight bytes");

   a_digest_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT) && (!rsp_valid_ff || rsp_tready) |=> rsp_tvalid)
      else $error("digest not presented");
`endif

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import shamd_pkg::*;

   // Row of the directed stimulus table.
   typedef struct {
      entry_type request;
      bit        typed;
      hash_type  digest;
   } directed_row_type;

   // Well-known digests, word 0 in the lowest bits.
   localparam hash_type EMPTY_DIGEST = {32'hafd80709, 32'h95601890, 32'h3255bfef,
                                        32'h5e6b4b0d, 32'hda39a3ee};
   localparam hash_type ABC_DIGEST   = {32'h9cd0d89d, 32'h7850c26c, 32'hba3e2571,
                                        32'h4706816a, 32'ha9993e36};

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [7:0]   req_tdata;   // [7:0] msg_byte
   logic         req_tuser;   // [0] byte_present
   logic         req_tlast;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [159:0] rsp_tdata;   // [31:0] word0, [63:32] word1, ... [159:128] word4

   // Predictor state of the hash.
   hash_type     chain_state = INIT_HASH;
   logic [31:0]  msg_block [16];
   logic [60:0]  byte_total = '0;

   // Digests still owed by the block, oldest first.
   hash_type     digest_queue [$];
   int           error_count = 0;

   // Digest typed into the directed table for the request on the bus.
   bit           cur_typed_valid = 1'b0;
   hash_type     cur_typed_digest = '0;

   directed_row_type directed_rows [$];
   int            boundary_lengths [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};

   sha1_message_digest u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Clock with a 4 ns period.
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Print one mismatch line and count it.
   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      error_count++;
   endtask

   // Gap length: mostly none or short, now and then long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return 0;
      end else if (r < 85) begin
         return $urandom_range(1, 3);
      end else if (r < 97) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 40);
   endfunction

   // Store one byte at a position of the big-endian block.
   function automatic void block_put(input int pos, input logic [7:0] b);
      int wi;
      int sh;
      wi = pos / 4;
      sh = (3 - pos % 4) * 8;
      if (pos % 4 == 0) begin
         msg_block[wi] = {b, 24'h0};
      end else begin
         msg_block[wi][sh +: 8] = b;
      end
   endfunction

   // One 80-round compression of the block into the chaining state.
   function automatic void block_compress();
      logic [31:0] w [16];
      logic [31:0] a, b, c, d, e, f, k, t, wt;
      w = msg_block;
      a = chain_state[0];
      b = chain_state[1];
      c = chain_state[2];
      d = chain_state[3];
      e = chain_state[4];
      for (int i = 0; i < 80; i++) begin
         if (i < 16) begin
            wt = w[i];
         end else begin
            wt = w[(i + 13) % 16] ^ w[(i + 8) % 16] ^ w[(i + 2) % 16] ^ w[i % 16];
            wt = {wt[30:0], wt[31]};
            w[i % 16] = wt;
         end
         if (i < 20) begin
            f = (b & c) | (~b & d);
            k = 32'h5A827999;
         end else if (i < 40) begin
            f = b ^ c ^ d;
            k = 32'h6ED9EBA1;
         end else if (i < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = 32'h8F1BBCDC;
         end else begin
            f = b ^ c ^ d;
            k = 32'hCA62C1D6;
         end
         t = {a[26:0], a[31:27]} + f + e + k + wt;
         e = d;
         d = c;
         c = {b[1:0], b[31:2]};
         b = a;
         a = t;
      end
      chain_state[0] = chain_state[0] + a;
      chain_state[1] = chain_state[1] + b;
      chain_state[2] = chain_state[2] + c;
      chain_state[3] = chain_state[3] + d;
      chain_state[4] = chain_state[4] + e;
   endfunction

   // Take one request into the predicted hash; a digest comes out on an end mark.
   task automatic digest_absorb(input entry_type request, output bit produced,
                                output hash_type digest);
      int          pos;
      logic [63:0] bit_length;
      produced = 1'b0;
      digest = '0;
      if (request.byte_present) begin
         pos = int'(byte_total[5:0]);
         block_put(pos, request.msg_byte);
         byte_total = byte_total + 61'd1;
         if (pos == 63) begin
            block_compress();
         end
      end
      if (request.end_of_message) begin
         // Pad byte, zeros, and the bit length; a late pad needs an extra block.
         pos = int'(byte_total[5:0]);
         block_put(pos, PAD_BYTE);
         for (int i = pos + 1; i < 64; i++) begin
            block_put(i, 8'h00);
         end
         if (pos >= 56) begin
            block_compress();
            for (int i = 0; i < 16; i++) begin
               msg_block[i] = '0;
            end
         end
         bit_length = {byte_total, 3'b000};
         msg_block[14] = bit_length[63:32];
         msg_block[15] = bit_length[31:0];
         block_compress();
         produced = 1'b1;
         digest = chain_state;
         chain_state = INIT_HASH;
         byte_total = '0;
      end
   endtask

   // Drive one request after a random gap and wait until it is taken.
   task automatic send_request(input entry_type request, input bit typed,
                               input hash_type digest);
      int gap;
      gap = pick_gap();
      repeat (gap) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= request.msg_byte;
      req_tuser  <= request.byte_present;
      req_tlast  <= request.end_of_message;
      cur_typed_valid  = typed;
      cur_typed_digest = digest;
      do begin
         @(posedge clock);
      end while (!req_tready);
   endtask

   function automatic void add_row(input logic [7:0] msg_byte, input logic present,
                                   input logic last, input bit typed,
                                   input hash_type digest);
      directed_row_type row;
      row.request.msg_byte       = msg_byte;
      row.request.byte_present   = present;
      row.request.end_of_message = last;
      row.typed  = typed;
      row.digest = digest;
      directed_rows.insert(directed_rows.size(), row);
   endfunction

   // Check each digest taken and predict from each request taken.
   always @(posedge clock) begin
      entry_type request;
      hash_type  want;
      hash_type  predicted;
      bit        produced;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (digest_queue.size() == 0) begin
               report_mismatch($sformatf("digest %h with none pending", rsp_tdata));
            end else begin
               want = digest_queue.pop_front();
               for (int i = 0; i < 5; i++) begin
                  if (rsp_tdata[i*32 +: 32] !== want[i]) begin
                     report_mismatch($sformatf("digest word%0d got %h want %h", i,
                                               rsp_tdata[i*32 +: 32], want[i]));
                  end
               end
            end
         end
         if (req_tvalid && req_tready) begin
            request.msg_byte       = req_tdata;
            request.byte_present   = req_tuser;
            request.end_of_message = req_tlast;
            digest_absorb(request, produced, predicted);
            if (produced) begin
               digest_queue.insert(digest_queue.size(),
                                   cur_typed_valid ? cur_typed_digest : predicted);
            end
         end
      end
   end

   // Result side: ready runs of random length broken by stalls.
   initial begin
      int run;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
         repeat (run) begin
            @(negedge clock);
            rsp_tready <= 1'b1;
         end
         run = pick_gap();
         repeat (run) begin
            @(negedge clock);
            rsp_tready <= 1'b0;
         end
      end
   end

   // Stimulus: reset, directed table, then random messages.
   initial begin
      entry_type request;
      int        len;
      int        r;
      int        items_sent;
      bit        end_on_byte;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      req_tlast  = 1'b0;
      items_sent = 0;
      for (int i = 0; i < 16; i++) begin
         msg_block[i] = '0;
      end

      // Empty messages, an ignored request, "abc", extreme bytes, end marks.
      add_row(8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST);
      add_row(8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST);
      add_row(8'h5a, 1'b0, 1'b0, 1'b0, '0);
      add_row(8'h61, 1'b1, 1'b0, 1'b0, '0);
      add_row(8'h62, 1'b1, 1'b0, 1'b0, '0);
      add_row(8'h63, 1'b1, 1'b1, 1'b1, ABC_DIGEST);
      add_row(8'hff, 1'b1, 1'b0, 1'b0, '0);
      add_row(8'h00, 1'b1, 1'b0, 1'b0, '0);
      add_row(8'h3c, 1'b0, 1'b0, 1'b0, '0);
      add_row(8'h80, 1'b1, 1'b0, 1'b0, '0);
      add_row(8'h7f, 1'b1, 1'b0, 1'b0, '0);
      add_row(8'hff, 1'b0, 1'b1, 1'b0, '0);
      add_row(8'hff, 1'b1, 1'b1, 1'b0, '0);
      add_row(8'h00, 1'b1, 1'b1, 1'b0, '0);

      repeat (3) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_request(directed_rows[i].request, directed_rows[i].typed,
                      directed_rows[i].digest);
      end

      // Random messages, mostly short, some at block and padding boundaries.
      while (items_sent < 1200) begin
         r = $urandom_range(0, 99);
         if (r < 60) begin
            len = $urandom_range(0, 20);
         end else if (r < 85) begin
            len = boundary_lengths[$urandom_range(0, 9)];
         end else begin
            len = $urandom_range(0, 150);
         end
         end_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
         for (int j = 0; j < len; j++) begin
            if ($urandom_range(0, 19) == 0) begin
               request.msg_byte       = 8'($urandom());
               request.byte_present   = 1'b0;
               request.end_of_message = 1'b0;
               send_request(request, 1'b0, '0);
            end
            request.msg_byte       = 8'($urandom());
            request.byte_present   = 1'b1;
            request.end_of_message = end_on_byte && (j == len - 1);
            send_request(request, 1'b0, '0);
            items_sent++;
         end
         if (!end_on_byte) begin
            request.msg_byte       = 8'($urandom());
            request.byte_present   = 1'b0;
            request.end_of_message = 1'b1;
            send_request(request, 1'b0, '0);
            items_sent++;
         end
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      cur_typed_valid = 1'b0;

      // Drain owed digests, then watch for strays.
      while (digest_queue.size() != 0) begin
         @(posedge clock);
      end
      repeat (400) @(posedge clock);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Watchdog on the whole run.
   initial begin
      #20000000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

// File: sim.f
design/shamd_pkg.sv
design/shamd_front.sv
design/shamd_core.sv
design/sha1_message_digest.sv
dv/testbench.sv
